FILE: src/ewd_pkg.sv
package ewd_pkg;

  typedef enum logic [2:0] {
    PH_CHARSET = 3'd0,
    PH_ENC     = 3'd1,
    PH_SEP_OK  = 3'd2,
    PH_SEP_BAD = 3'd3,
    PH_CONTENT = 3'd4,
    PH_B64_END = 3'd5,
    PH_FAILED  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_EQ   = 2'd1,
    ESC_HEX  = 2'd2,
    ESC_CR   = 2'd3
  } esc_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SEP    = 2'd1,
    ST_BAD_ENC   = 2'd2,
    ST_BAD_DIGIT = 2'd3
  } status_t;

  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UQ    = 8'h51;
  localparam logic [7:0] CH_LQ    = 8'h71;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LB    = 8'h62;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } b64_t;

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t r;
    r = '{ok: 1'b0, val: 4'd0};
    if (c >= 8'h41 && c <= 8'h46) r = '{ok: 1'b1, val: 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = '{ok: 1'b1, val: 4'(c - 8'h57)};
    else if (c >= 8'h30 && c <= 8'h39) r = '{ok: 1'b1, val: 4'(c - 8'h30)};
    return r;
  endfunction

  function automatic b64_t b64_val(input logic [7:0] c);
    b64_t r;
    r = '{ok: 1'b0, val: 6'd0};
    if (c >= 8'h41 && c <= 8'h5A) r = '{ok: 1'b1, val: 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = '{ok: 1'b1, val: 6'(c - 8'h47)};
    else if (c >= 8'h30 && c <= 8'h39) r = '{ok: 1'b1, val: 6'(c + 8'h04)};
    else if (c == CH_PLUS) r = '{ok: 1'b1, val: 6'd62};
    else if (c == CH_SLASH) r = '{ok: 1'b1, val: 6'd63};
    return r;
  endfunction

endpackage

FILE: src/encoded_word_decoder.sv
// The result of an accepted byte is registered in the output register.
// Throughput: one input byte per cycle; in_ready follows out_ready while a result
// waits in the output register.
// Reset: rst_n low (synchronous) clears the decode state to the charset
// phase and empties the output register.
module encoded_word_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_done_res,
  output logic [1:0] out_status
);
  import ewd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       b64_r, b64_nxt;
  esc_t       esc_r, esc_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic [5:0] acc_r, acc_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  status_t    fail_r, fail_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r, byte_c;
  logic       out_byte_valid_r, have_c;
  logic       out_done_r;
  status_t    out_status_r, st_c;

  logic       accept;
  logic       emit;
  hex_t       hx;
  b64_t       bx;
  logic [11:0] wide;
  logic [3:0]  wcnt;
  logic [2:0]  rem;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign hx   = hex_val(in_byte);
  assign bx   = b64_val(in_byte);
  assign wide = {acc_r, bx.val};
  assign wcnt = {1'b0, cnt_r} + 4'd6;
  assign rem  = 3'(wcnt - 4'd8);

  always_comb begin
    phase_nxt = phase_r;
    b64_nxt   = b64_r;
    esc_nxt   = esc_r;
    hi_nxt    = hi_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    fail_nxt  = fail_r;
    byte_c    = 8'd0;
    have_c    = 1'b0;
    st_c      = ST_OK;

    unique case (phase_r)
      PH_CHARSET: begin
        if (in_byte == CH_QMARK) phase_nxt = PH_ENC;
      end
      PH_ENC: begin
        if (in_byte == CH_UQ || in_byte == CH_LQ) begin
          b64_nxt = 1'b0;
          phase_nxt = PH_SEP_OK;
        end else if (in_byte == CH_UB || in_byte == CH_LB) begin
          b64_nxt = 1'b1;
          phase_nxt = PH_SEP_OK;
        end else begin
          phase_nxt = PH_SEP_BAD;
        end
      end
      PH_SEP_OK: begin
        if (in_byte == CH_QMARK) phase_nxt = PH_CONTENT;
        else begin
          phase_nxt = PH_FAILED;
          fail_nxt = ST_NO_SEP;
        end
      end
      PH_SEP_BAD: begin
        phase_nxt = PH_FAILED;
        fail_nxt  = (in_byte == CH_QMARK) ? ST_BAD_ENC : ST_NO_SEP;
      end
      PH_CONTENT: begin
        if (b64_r) begin
          if (in_byte == CH_EQ) phase_nxt = PH_B64_END;
          else if (in_byte == CH_SPACE || in_byte == CH_TAB ||
                   in_byte == CH_CR || in_byte == CH_LF) begin
            // skip whitespace
          end else if (!bx.ok) begin
            phase_nxt = PH_FAILED;
            fail_nxt = ST_BAD_DIGIT;
          end else if (wcnt >= 4'd8) begin
            // a full byte is ready: take its top bits, keep the remainder
            have_c  = 1'b1;
            cnt_nxt = rem;
            unique case (rem)
              3'd0: begin byte_c = wide[7:0];  acc_nxt = 6'd0; end
              3'd2: begin byte_c = wide[9:2];  acc_nxt = {4'd0, wide[1:0]}; end
              3'd4: begin byte_c = wide[11:4]; acc_nxt = {2'd0, wide[3:0]}; end
              default: begin byte_c = wide[11:4]; acc_nxt = wide[5:0]; end
            endcase
          end else begin
            acc_nxt = wide[5:0];
            cnt_nxt = wcnt[2:0];
          end
        end else begin
          unique case (esc_r)
            ESC_NONE: begin
              if (in_byte == CH_EQ) esc_nxt = ESC_EQ;
              else begin
                have_c = 1'b1;
                byte_c = (in_byte == CH_UNDER) ? CH_SPACE : in_byte;
              end
            end
            ESC_EQ: begin
              if (hx.ok) begin
                hi_nxt  = hx.val;
                esc_nxt = ESC_HEX;
              end else if (in_byte == CH_CR) esc_nxt = ESC_CR;
              else if (in_byte == CH_LF) esc_nxt = ESC_NONE;
              else begin
                phase_nxt = PH_FAILED;
                fail_nxt = ST_BAD_DIGIT;
              end
            end
            ESC_HEX: begin
              if (hx.ok) begin
                have_c  = 1'b1;
                byte_c  = {hi_r, hx.val};
                esc_nxt = ESC_NONE;
              end else begin
                phase_nxt = PH_FAILED;
                fail_nxt = ST_BAD_DIGIT;
              end
            end
            ESC_CR: begin
              if (in_byte == CH_LF) esc_nxt = ESC_NONE;
              else begin
                phase_nxt = PH_FAILED;
                fail_nxt = ST_BAD_DIGIT;
              end
            end
          endcase
        end
      end
      default: begin
        // ended base64 or failed: drop the byte
      end
    endcase

    if (in_last_byte) begin
      if (phase_nxt == PH_FAILED) st_c = fail_nxt;
      else if (phase_nxt == PH_CHARSET || phase_nxt == PH_ENC ||
               phase_nxt == PH_SEP_OK || phase_nxt == PH_SEP_BAD) st_c = ST_NO_SEP;
      else if (phase_nxt == PH_CONTENT && !b64_nxt && esc_nxt != ESC_NONE)
        st_c = ST_BAD_DIGIT;
      if (st_c != ST_OK) begin
        have_c = 1'b0;
        byte_c = 8'd0;
      end
      phase_nxt = PH_CHARSET;
      b64_nxt   = 1'b0;
      esc_nxt   = ESC_NONE;
      hi_nxt    = 4'd0;
      acc_nxt   = 6'd0;
      cnt_nxt   = 3'd0;
      fail_nxt  = ST_OK;
    end
  end

  assign emit = accept && (have_c || in_last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CHARSET;
      b64_r       <= 1'b0;
      esc_r       <= ESC_NONE;
      hi_r        <= 4'd0;
      acc_r       <= 6'd0;
      cnt_r       <= 3'd0;
      fail_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        b64_r   <= b64_nxt;
        esc_r   <= esc_nxt;
        hi_r    <= hi_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        fail_r  <= fail_nxt;
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r       <= byte_c;
      out_byte_valid_r <= have_c;
      out_done_r       <= in_last_byte;
      out_status_r     <= st_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_byte_valid_r;
  assign out_done_res   = out_done_r;
  assign out_status     = out_status_r;

  a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_byte_valid && out_done_res)
    else $error("error status with a decoded byte or without done");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_byte |=> phase_r == PH_CHARSET && fail_r == ST_OK)
    else $error("state not cleared after the last byte");

  a_cnt_even: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 3'd0 || cnt_r == 3'd2 || cnt_r == 3'd4 || cnt_r == 3'd6)
    else $error("base64 bit count out of range");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with an empty output register");

endmodule
